// ===== sv/assert_macros.svh =====
// Assertion helpers for the vertex projection block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent on the same edge
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent on the next edge
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/vrp_pkg.sv =====
// ----------------------------------------------------------------------------
// vrp_pkg
// Types, constants and the sine table for the vertex rotate/project pipe.
// ----------------------------------------------------------------------------
package vrp_pkg;

    localparam int SCREEN_W    = 256;
    localparam int SCREEN_H    = 240;
    localparam int ONE_Q       = 256;
    localparam int Z_FLOOR     = 512;
    localparam logic signed [15:0] DEPTH_RESET = 16'sd768;

    // quotient stages: 10 bits of quotient; 1024 and above saturate
    localparam int QBITS       = 10;
    localparam int DIV_STEPS   = 5;   // bits per stage = 2
    // rotate stages, divide stages, output register
    localparam int LATENCY     = 3 + DIV_STEPS + 1;

    typedef struct packed {
        logic signed [15:0] vert_x;
        logic signed [15:0] vert_y;
        logic signed [15:0] vert_z;
        logic        [7:0]  angle;
    } t_vert_in;

    typedef struct packed {
        logic [8:0] screen_x;
        logic [7:0] screen_y;
    } t_screen_out;

    // divider lane state
    typedef struct packed {
        logic              neg;
        logic              sat;   // quotient known to exceed the clamp
        logic [25:0]       rem;   // running remainder, scaled by 2 each step
        logic [QBITS-1:0]  quo;
    } t_div_lane;

    function automatic logic [8:0] quarter_sine(input logic [6:0] i);
        logic [8:0] v;
        case (i)
            7'd0: v = 9'd0;     7'd1: v = 9'd6;     7'd2: v = 9'd13;    7'd3: v = 9'd19;
            7'd4: v = 9'd25;    7'd5: v = 9'd31;    7'd6: v = 9'd38;    7'd7: v = 9'd44;
            7'd8: v = 9'd50;    7'd9: v = 9'd56;    7'd10: v = 9'd62;   7'd11: v = 9'd68;
            7'd12: v = 9'd74;   7'd13: v = 9'd80;   7'd14: v = 9'd86;   7'd15: v = 9'd92;
            7'd16: v = 9'd98;   7'd17: v = 9'd104;  7'd18: v = 9'd109;  7'd19: v = 9'd115;
            7'd20: v = 9'd121;  7'd21: v = 9'd126;  7'd22: v = 9'd132;  7'd23: v = 9'd137;
            7'd24: v = 9'd142;  7'd25: v = 9'd147;  7'd26: v = 9'd152;  7'd27: v = 9'd157;
            7'd28: v = 9'd162;  7'd29: v = 9'd167;  7'd30: v = 9'd172;  7'd31: v = 9'd177;
            7'd32: v = 9'd181;  7'd33: v = 9'd185;  7'd34: v = 9'd190;  7'd35: v = 9'd194;
            7'd36: v = 9'd198;  7'd37: v = 9'd202;  7'd38: v = 9'd206;  7'd39: v = 9'd209;
            7'd40: v = 9'd213;  7'd41: v = 9'd216;  7'd42: v = 9'd220;  7'd43: v = 9'd223;
            7'd44: v = 9'd226;  7'd45: v = 9'd229;  7'd46: v = 9'd231;  7'd47: v = 9'd234;
            7'd48: v = 9'd237;  7'd49: v = 9'd239;  7'd50: v = 9'd241;  7'd51: v = 9'd243;
            7'd52: v = 9'd245;  7'd53: v = 9'd247;  7'd54: v = 9'd248;  7'd55: v = 9'd250;
            7'd56: v = 9'd251;  7'd57: v = 9'd252;  7'd58: v = 9'd253;  7'd59: v = 9'd254;
            7'd60: v = 9'd255;  7'd61: v = 9'd255;  7'd62: v = 9'd256;  7'd63: v = 9'd256;
            7'd64: v = 9'd256;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [9:0] sine_rom(input logic [7:0] a);
        logic [8:0] m;
        if (a[6]) begin
            m = quarter_sine(7'd64 - {1'b0, a[5:0]});
        end else begin
            m = quarter_sine({1'b0, a[5:0]});
        end
        return a[7] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

endpackage

// ===== sv/vrp_rotate.sv =====
// ----------------------------------------------------------------------------
// vrp_rotate
// Sine lookup, four Q8.8 products, rotation sums and depth clamp.
// Three register stages; outputs rx, y and clamped z.
// ----------------------------------------------------------------------------
module vrp_rotate
    import vrp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_vert_in            i_vert,
    input  logic signed [15:0]  i_depth_offset,
    output logic                o_valid,
    output logic signed [15:0]  o_rx,
    output logic signed [15:0]  o_y,
    output logic        [15:0]  o_z
);

    // stage 1: sine/cosine
    logic               r_v1;
    logic signed [15:0] r_x1, r_y1, r_z1;
    logic signed [9:0]  r_s1, r_c1;
    // stage 2: products
    logic               r_v2;
    logic signed [15:0] r_y2, r_xc2, r_zs2, r_xs2, r_zc2;
    // stage 3: sums and clamp
    logic               r_v3;
    logic signed [15:0] r_rx3, r_y3;
    logic        [15:0] r_z3;

    logic signed [25:0] n_xc, n_zs, n_xs, n_zc;
    logic signed [15:0] n_rz, n_zd;

    assign n_xc = r_x1 * r_c1;
    assign n_zs = r_z1 * r_s1;
    assign n_xs = r_x1 * r_s1;
    assign n_zc = r_z1 * r_c1;

    always_comb begin
        n_rz = r_xs2 + r_zc2;
        n_zd = n_rz + i_depth_offset;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_x1  <= i_vert.vert_x;
        r_y1  <= i_vert.vert_y;
        r_z1  <= i_vert.vert_z;
        r_s1  <= sine_rom(i_vert.angle);
        r_c1  <= sine_rom(i_vert.angle + 8'd64);
        r_y2  <= r_y1;
        r_xc2 <= n_xc[23:8];
        r_zs2 <= n_zs[23:8];
        r_xs2 <= n_xs[23:8];
        r_zc2 <= n_zc[23:8];
        r_y3  <= r_y2;
        r_rx3 <= r_xc2 - r_zs2;
        r_z3  <= (n_zd < $signed(16'(Z_FLOOR))) ? 16'(Z_FLOOR) : n_zd;
    end

    assign o_valid = r_v3;
    assign o_rx    = r_rx3;
    assign o_y     = r_y3;
    assign o_z     = r_z3;

endmodule

// ===== sv/vrp_div_stage.sv =====
// ----------------------------------------------------------------------------
// vrp_div_stage
// One registered step of the restoring divider: two quotient bits for each
// of the x and y lanes, which share the same divisor.
// ----------------------------------------------------------------------------
module vrp_div_stage
    import vrp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [15:0] i_z,
    input  t_div_lane   i_lx,
    input  t_div_lane   i_ly,
    output logic        o_valid,
    output logic [15:0] o_z,
    output t_div_lane   o_lx,
    output t_div_lane   o_ly
);

    logic        r_v;
    logic [15:0] r_z;
    t_div_lane   r_lx, r_ly;
    t_div_lane   n_lx, n_ly;

    // rem is the remainder scaled up by one bit per step, so the divisor
    // stays fixed at z << (QBITS-1)
    function automatic t_div_lane step2(input t_div_lane l, input logic [15:0] z);
        t_div_lane  o;
        logic [26:0] t;
        o = l;
        for (int k = 0; k < 2; k++) begin
            t = {1'b0, o.rem} - {2'b0, z, 9'd0};
            o.quo = {o.quo[QBITS-2:0], ~t[26]};
            if (!t[26]) begin
                o.rem = t[25:0];
            end
            o.rem = {o.rem[24:0], 1'b0};
        end
        return o;
    endfunction

    assign n_lx = step2(i_lx, i_z);
    assign n_ly = step2(i_ly, i_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_valid;
        end
        r_z  <= i_z;
        r_lx <= n_lx;
        r_ly <= n_ly;
    end

    assign o_valid = r_v;
    assign o_z     = r_z;
    assign o_lx    = r_lx;
    assign o_ly    = r_ly;

endmodule

// ===== sv/vertex_rotate_project_core.sv =====
// ----------------------------------------------------------------------------
// vertex_rotate_project_core
// Rotates a Q8.8 vertex about Y and projects it to screen coordinates.
// Pipeline from start to o_result_valid: 3 rotate, 5 divide, 1 out stage.
// Throughput: one item per cycle; busy is always low, results never stall.
// Divide is five 2-bit restoring steps, one register stage each.
// Reset (synchronous, active low) clears valid bits, sets depth_offset to 3.0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vertex_rotate_project_core
    import vrp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_vert_in           i_vert,
    input  logic               i_cfg_we,
    input  logic signed [15:0] i_cfg_data,
    output logic               o_result_valid,
    output t_screen_out        o_result
);

    logic signed [15:0] r_depth_offset;
    logic               n_accept;

    logic               rot_valid;
    logic signed [15:0] rot_rx, rot_y;
    logic        [15:0] rot_z;

    logic [DIV_STEPS:0] dv;
    logic [15:0]        dz [DIV_STEPS+1];
    t_div_lane          dlx [DIV_STEPS+1];
    t_div_lane          dly [DIV_STEPS+1];

    logic               r_out_v;
    t_screen_out        r_out;
    logic signed [10:0] n_px, n_py;
    logic [9:0]         n_ux, n_uy;
    logic [22:0]        n_wx;
    logic [8:0]         n_sx;
    logic [21:0]        n_sy;
    logic [8:0]         n_hy;

    assign busy     = 1'b0;
    assign n_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_offset <= DEPTH_RESET;
        end else if (i_cfg_we) begin
            r_depth_offset <= i_cfg_data;
        end
    end

    vrp_rotate u_rotate (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (n_accept),
        .i_vert         (i_vert),
        .i_depth_offset (r_depth_offset),
        .o_valid        (rot_valid),
        .o_rx           (rot_rx),
        .o_y            (rot_y),
        .o_z            (rot_z)
    );

    // |v|*256 / z: quotients of 1024 and up all clamp alike, so they are
    // flagged up front and the divider only has to produce 10 bits.
    function automatic t_div_lane lane_init(input logic signed [15:0] v,
                                            input logic [15:0] z);
        t_div_lane   l;
        logic [16:0] m;
        m     = v[15] ? 17'(-$signed({v[15], v})) : {1'b0, v};
        l.neg = v[15];
        l.sat = ({1'b0, m} >= {z, 2'b00});
        l.rem = l.sat ? '0 : 26'({m, 8'd0});
        l.quo = '0;
        return l;
    endfunction

    assign dv[0]  = rot_valid;
    assign dz[0]  = rot_z;
    assign dlx[0] = lane_init(rot_rx, rot_z);
    assign dly[0] = lane_init(rot_y, rot_z);

    genvar g;
    generate
        for (g = 0; g < DIV_STEPS; g++) begin : g_div
            vrp_div_stage u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (dv[g]),
                .i_z     (dz[g]),
                .i_lx    (dlx[g]),
                .i_ly    (dly[g]),
                .o_valid (dv[g+1]),
                .o_z     (dz[g+1]),
                .o_lx    (dlx[g+1]),
                .o_ly    (dly[g+1])
            );
        end
    endgenerate

    function automatic logic signed [10:0] clamp_q(input t_div_lane l);
        logic [9:0] q;
        q = (l.sat || l.quo > 10'(ONE_Q)) ? 10'(ONE_Q) : l.quo;
        return l.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    always_comb begin
        n_px = clamp_q(dlx[DIV_STEPS]);
        n_py = clamp_q(dly[DIV_STEPS]);
        n_ux = 10'(n_px + 11'sd256);
        n_uy = 10'(n_py + 11'sd256);
        n_wx = 23'(n_ux) * 23'(SCREEN_W);
        n_sx = n_wx[17:9];
        // (py+256)/2 with py+256 >= 0 is a shift
        n_hy = n_uy[9:1];
        n_sy = 22'(9'd256 - n_hy) * 22'(SCREEN_H);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= dv[DIV_STEPS];
        end
        r_out.screen_x <= n_sx;
        r_out.screen_y <= n_sy[15:8];
    end

    assign o_result_valid = r_out_v;
    assign o_result       = r_out;

    `ASSERT_NXT(a_lat_rot, i_clk, i_rst_n, n_accept, u_rotate.r_v1, "rotate stage lost an item")
    `ASSERT_IMP(a_zfloor, i_clk, i_rst_n, rot_valid, rot_z >= 16'(Z_FLOOR), "depth below floor")
    `ASSERT_IMP(a_quo, i_clk, i_rst_n, r_out_v, r_out.screen_x <= 9'd256, "screen x out of range")

endmodule
